// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the round cell
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/s256c_pkg.sv =====
// types, constants and round functions for the sha-256 cascade pipeline
package s256c_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PAIR_W     = 2 * WORD_W;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int unsigned NUM_ROUNDS = 3;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [PAIR_W-1:0]    pair_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef word_t [NUM_REGS-1:0] state_t;

  typedef struct packed {
    state_t                  s1;
    state_t                  s2;
    word_t [NUM_ROUNDS-1:0]  w;
  } pair_t;

  localparam word_t [NUM_ROUNDS-1:0] ROUND_K = '{
    32'h8cc70208, 32'h84c87814, 32'h78a5636f
  };

  localparam int unsigned REG_A = 0;
  localparam int unsigned REG_B = 1;
  localparam int unsigned REG_C = 2;
  localparam int unsigned REG_D = 3;
  localparam int unsigned REG_E = 4;
  localparam int unsigned REG_F = 5;
  localparam int unsigned REG_G = 6;
  localparam int unsigned REG_H = 7;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return word_t'((x >> n) | (x << (WORD_W - n)));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/core/s256c_in_if.sv =====
// request channel carrying the three message-1 schedule words
interface s256c_in_if;
  logic                  valid;
  logic                  ready;
  s256c_pkg::word_t      word_round57;
  s256c_pkg::word_t      word_round58;
  s256c_pkg::word_t      word_round59;

  modport source (output valid, word_round57, word_round58, word_round59, input ready);
  modport sink   (input valid, word_round57, word_round58, word_round59, output ready);
endinterface

// ===== rtl/core/s256c_out_if.sv =====
// result channel carrying both working states after round 59
interface s256c_out_if;
  logic                    valid;
  logic                    ready;
  s256c_pkg::pair_word_t   result_pair_a;
  s256c_pkg::pair_word_t   result_pair_b;
  s256c_pkg::pair_word_t   result_pair_c;
  s256c_pkg::pair_word_t   result_pair_d;
  s256c_pkg::pair_word_t   result_pair_e;
  s256c_pkg::pair_word_t   result_pair_f;
  s256c_pkg::pair_word_t   result_pair_g;
  s256c_pkg::pair_word_t   result_pair_h;

  modport source (output valid, result_pair_a, result_pair_b, result_pair_c, result_pair_d,
                  result_pair_e, result_pair_f, result_pair_g, result_pair_h, input ready);
  modport sink   (input valid, result_pair_a, result_pair_b, result_pair_c, result_pair_d,
                  result_pair_e, result_pair_f, result_pair_g, result_pair_h, output ready);
endinterface

// ===== rtl/core/s256c_cell.sv =====
// one cascade round on a pair of states, two register stages
`include "assert_macros.svh"

module s256c_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  s256c_pkg::pair_t  in_data,
  input  s256c_pkg::word_t  k,
  output logic              out_vld,
  input  logic              out_rdy,
  output s256c_pkg::pair_t  out_data
);
  import s256c_pkg::*;

  logic   vld_a_r, vld_b_r;
  logic   rdy_a, rdy_b;
  pair_t  data_a_r, data_b_r, data_b_nxt;
  word_t  p1_r, t2_1_r, t2_2_r;
  word_t  p1_nxt, t2_1_nxt, t2_2_nxt;
  word_t  sum1, a_new, e1_new, e2_new;

  assign rdy_b  = !vld_b_r || out_rdy;
  assign rdy_a  = !vld_a_r || rdy_b;
  assign in_rdy = rdy_a;

  // stage a: partial t1 of message 1 and t2 of both states
  always_comb begin
    p1_nxt   = in_data.s1[REG_H] + big_sig1(in_data.s1[REG_E])
             + choose(in_data.s1[REG_E], in_data.s1[REG_F], in_data.s1[REG_G]) + k;
    t2_1_nxt = big_sig0(in_data.s1[REG_A])
             + major(in_data.s1[REG_A], in_data.s1[REG_B], in_data.s1[REG_C]);
    t2_2_nxt = big_sig0(in_data.s2[REG_A])
             + major(in_data.s2[REG_A], in_data.s2[REG_B], in_data.s2[REG_C]);
  end

  // stage b: cascade makes both new a equal; message-2 e follows from it
  always_comb begin
    sum1   = p1_r + data_a_r.w[0];
    a_new  = sum1 + t2_1_r;
    e1_new = data_a_r.s1[REG_D] + sum1;
    e2_new = data_a_r.s2[REG_D] + a_new - t2_2_r;

    data_b_nxt        = data_a_r;
    data_b_nxt.s1[REG_A] = a_new;
    data_b_nxt.s1[REG_B] = data_a_r.s1[REG_A];
    data_b_nxt.s1[REG_C] = data_a_r.s1[REG_B];
    data_b_nxt.s1[REG_D] = data_a_r.s1[REG_C];
    data_b_nxt.s1[REG_E] = e1_new;
    data_b_nxt.s1[REG_F] = data_a_r.s1[REG_E];
    data_b_nxt.s1[REG_G] = data_a_r.s1[REG_F];
    data_b_nxt.s1[REG_H] = data_a_r.s1[REG_G];
    data_b_nxt.s2[REG_A] = a_new;
    data_b_nxt.s2[REG_B] = data_a_r.s2[REG_A];
    data_b_nxt.s2[REG_C] = data_a_r.s2[REG_B];
    data_b_nxt.s2[REG_D] = data_a_r.s2[REG_C];
    data_b_nxt.s2[REG_E] = e2_new;
    data_b_nxt.s2[REG_F] = data_a_r.s2[REG_E];
    data_b_nxt.s2[REG_G] = data_a_r.s2[REG_F];
    data_b_nxt.s2[REG_H] = data_a_r.s2[REG_G];
    // next cell takes the following word
    for (int i = 0; i < NUM_ROUNDS - 1; i++) begin
      data_b_nxt.w[i] = data_a_r.w[i+1];
    end
    data_b_nxt.w[NUM_ROUNDS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a_r <= in_vld;
      end
      if (rdy_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_vld) begin
      data_a_r <= in_data;
      p1_r     <= p1_nxt;
      t2_1_r   <= t2_1_nxt;
      t2_2_r   <= t2_2_nxt;
    end
    if (rdy_b && vld_a_r) begin
      data_b_r <= data_b_nxt;
    end
  end

  assign out_vld  = vld_b_r;
  assign out_data = data_b_r;

  `ASSERT_SAME(a_cascade_equal, clk, rst_n, vld_b_r, data_b_r.s1[REG_A] == data_b_r.s2[REG_A])
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, vld_b_r && !out_rdy, vld_b_r && $stable(data_b_r))
  `ASSERT_NEXT(a_stage_a_hold, clk, rst_n, vld_a_r && vld_b_r && !out_rdy, vld_a_r)

endmodule

// ===== rtl/core/sha256_cascade_three_round_pair.sv =====
// top level: configuration registers and a chain of three cascade round cells
//
//  channel | dir | contents
//  in_ch   | in  | word_round57..59, 32 bits each
//  out_ch  | out | result_pair_a..h, message 1 high, message 2 low
//  cfg_*   | in  | write enable, register index a..h, 64-bit data
//
// one request per cycle unless the output stalls; it passes stage a then b of each cell
// each round cell has two register stages; the last stage is the output register
// ready runs back combinationally through all six stages, so bubbles close up under stalls
// reset clears all stage valids and the base registers to zero
module sha256_cascade_three_round_pair (
  input  logic                     clk,
  input  logic                     rst_n,
  s256c_in_if.sink                 in_ch,
  s256c_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  s256c_pkg::cfg_idx_t      cfg_idx,
  input  s256c_pkg::pair_word_t    cfg_wdata
);
  import s256c_pkg::*;

  pair_word_t [NUM_REGS-1:0] base_r;
  logic  [NUM_ROUNDS:0] vld;
  logic  [NUM_ROUNDS:0] rdy;
  pair_t [NUM_ROUNDS:0] data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r[cfg_idx] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      data[0].s1[i] = base_r[i][PAIR_W-1:WORD_W];
      data[0].s2[i] = base_r[i][WORD_W-1:0];
    end
    data[0].w[0] = in_ch.word_round57;
    data[0].w[1] = in_ch.word_round58;
    data[0].w[2] = in_ch.word_round59;
  end

  assign vld[0]      = in_ch.valid;
  assign in_ch.ready = rdy[0];

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_cell
    s256c_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld[r]),
      .in_rdy   (rdy[r]),
      .in_data  (data[r]),
      .k        (ROUND_K[r]),
      .out_vld  (vld[r+1]),
      .out_rdy  (rdy[r+1]),
      .out_data (data[r+1])
    );
  end

  assign rdy[NUM_ROUNDS]      = out_ch.ready;
  assign out_ch.valid         = vld[NUM_ROUNDS];
  assign out_ch.result_pair_a = {data[NUM_ROUNDS].s1[REG_A], data[NUM_ROUNDS].s2[REG_A]};
  assign out_ch.result_pair_b = {data[NUM_ROUNDS].s1[REG_B], data[NUM_ROUNDS].s2[REG_B]};
  assign out_ch.result_pair_c = {data[NUM_ROUNDS].s1[REG_C], data[NUM_ROUNDS].s2[REG_C]};
  assign out_ch.result_pair_d = {data[NUM_ROUNDS].s1[REG_D], data[NUM_ROUNDS].s2[REG_D]};
  assign out_ch.result_pair_e = {data[NUM_ROUNDS].s1[REG_E], data[NUM_ROUNDS].s2[REG_E]};
  assign out_ch.result_pair_f = {data[NUM_ROUNDS].s1[REG_F], data[NUM_ROUNDS].s2[REG_F]};
  assign out_ch.result_pair_g = {data[NUM_ROUNDS].s1[REG_G], data[NUM_ROUNDS].s2[REG_G]};
  assign out_ch.result_pair_h = {data[NUM_ROUNDS].s1[REG_H], data[NUM_ROUNDS].s2[REG_H]};

endmodule

// ===== tb/sv/tb_sha256_cascade_three_round_pair.sv =====
// testbench for the three-round sha-256 cascade over a message-1 / message-2 state pair
module tb_sha256_cascade_three_round_pair;
  import s256c_pkg::*;

  typedef word_t [7:0] lane_t;
  typedef pair_word_t [7:0] pair_set_t;

  typedef enum int {
    BASE_ZERO, BASE_ONES, BASE_HIGH_ONES, BASE_LOW_ONES, BASE_EQUAL, BASE_ONE_BIT, BASE_RANDOM
  } base_kind_t;

  typedef struct packed {
    word_t w57;
    word_t w58;
    word_t w59;
    logic  zero_want;
  } dir_row_t;

  localparam word_t K57 = 32'h78a5636f;
  localparam word_t K58 = 32'h84c87814;
  localparam word_t K59 = 32'h8cc70208;
  localparam int DIRECTED_ROWS = 10;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 122;
  localparam int TAIL_CYCLES = 12;
  localparam int PRINT_CAP = 40;

  // zero_want: from an all-zero base, words that cancel each round constant leave zeros
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b0},
    '{32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0},
    '{32'h875a9c91, 32'h7b3787ec, 32'h7338fdf8, 1'b1},
    '{32'h80000000, 32'h00000001, 32'h7fffffff, 1'b0},
    '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0},
    '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b0},
    '{32'h875a9c91, 32'h00000000, 32'hffffffff, 1'b0},
    '{32'h00000001, 32'h80000000, 32'hfffffffe, 1'b0},
    '{32'h0f0f0f0f, 32'hf0f0f0f0, 32'h00ff00ff, 1'b0},
    '{32'hffffffff, 32'h00000000, 32'hffffffff, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_idx;
  pair_word_t cfg_wdata;

  s256c_in_if in_ch ();
  s256c_out_if out_ch ();

  sha256_cascade_three_round_pair DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pair_set_t base_pairs;
  pair_set_t round59_pairs [$];
  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int requests_sent;
  int results_seen;
  int base_settings;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic word_t ror(word_t x, int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic word_t sum_a(word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t sum_e(word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t pick(word_t e, word_t f, word_t g);
    return (e & f) | (~e & g);
  endfunction

  function automatic word_t vote(word_t a, word_t b, word_t c);
    return (a & b) | (c & (a | b));
  endfunction

  function automatic lane_t lane_step(lane_t s, word_t w, word_t k);
    word_t t1;
    word_t t2;
    lane_t n;
    t1 = s[REG_H] + sum_e(s[REG_E]) + pick(s[REG_E], s[REG_F], s[REG_G]) + k + w;
    t2 = sum_a(s[REG_A]) + vote(s[REG_A], s[REG_B], s[REG_C]);
    n[REG_H] = s[REG_G];
    n[REG_G] = s[REG_F];
    n[REG_F] = s[REG_E];
    n[REG_E] = s[REG_D] + t1;
    n[REG_D] = s[REG_C];
    n[REG_C] = s[REG_B];
    n[REG_B] = s[REG_A];
    n[REG_A] = t1 + t2;
    return n;
  endfunction

  function automatic word_t cascade_word(lane_t p, lane_t q);
    return (p[REG_H] - q[REG_H])
         + (sum_e(p[REG_E]) - sum_e(q[REG_E]))
         + (pick(p[REG_E], p[REG_F], p[REG_G]) - pick(q[REG_E], q[REG_F], q[REG_G]))
         + (sum_a(p[REG_A]) + vote(p[REG_A], p[REG_B], p[REG_C]))
         - (sum_a(q[REG_A]) + vote(q[REG_A], q[REG_B], q[REG_C]));
  endfunction

  function automatic pair_set_t cascade_rounds(pair_set_t base, word_t w57, word_t w58,
                                               word_t w59);
    lane_t m1;
    lane_t m2;
    word_t rw [3];
    word_t rk [3];
    word_t w2;
    pair_set_t res;
    for (int i = REG_A; i <= REG_H; i++) begin
      m1[i] = base[i][63:32];
      m2[i] = base[i][31:0];
    end
    rw[0] = w57;
    rw[1] = w58;
    rw[2] = w59;
    rk[0] = K57;
    rk[1] = K58;
    rk[2] = K59;
    for (int r = 0; r < 3; r++) begin
      w2 = rw[r] + cascade_word(m1, m2);
      m1 = lane_step(m1, rw[r], rk[r]);
      m2 = lane_step(m2, w2, rk[r]);
    end
    for (int i = REG_A; i <= REG_H; i++) res[i] = {m1[i], m2[i]};
    return res;
  endfunction

  function automatic pair_set_t make_base(base_kind_t kind);
    pair_set_t v;
    word_t hi;
    word_t lo;
    for (int i = REG_A; i <= REG_H; i++) begin
      hi = $urandom;
      lo = $urandom;
      case (kind)
        BASE_ZERO:      v[i] = '0;
        BASE_ONES:      v[i] = '1;
        BASE_HIGH_ONES: v[i] = {32'hffffffff, 32'h00000000};
        BASE_LOW_ONES:  v[i] = {32'h00000000, 32'hffffffff};
        BASE_EQUAL:     v[i] = {hi, hi};
        BASE_ONE_BIT:   v[i] = {hi, hi ^ (32'h1 << $urandom_range(31))};
        default:        v[i] = {hi, lo};
      endcase
    end
    return v;
  endfunction

  function automatic word_t pick_word(word_t k);
    case ($urandom_range(9))
      0: return -k;
      1: return '0;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    // quiet after the first PRINT_CAP mismatches
    if (error_count <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic check_round59();
    pair_set_t got;
    pair_set_t want;
    got[REG_A] = out_ch.result_pair_a;
    got[REG_B] = out_ch.result_pair_b;
    got[REG_C] = out_ch.result_pair_c;
    got[REG_D] = out_ch.result_pair_d;
    got[REG_E] = out_ch.result_pair_e;
    got[REG_F] = out_ch.result_pair_f;
    got[REG_G] = out_ch.result_pair_g;
    got[REG_H] = out_ch.result_pair_h;
    results_seen++;
    if (round59_pairs.size() == 0) begin
      report_error($sformatf("result with no request pending, a=%h", got[REG_A]));
    end else begin
      want = round59_pairs.pop_front();
      for (int i = REG_A; i <= REG_H; i++)
        if (got[i] !== want[i])
          report_error($sformatf("result %0d result_pair_%c got %h want %h",
                                 results_seen, 8'h61 + i, got[i], want[i]));
    end
  endtask

  always @(posedge clk)
    if (rst_n && out_ch.valid && out_ch.ready) check_round59();

  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic offer_request(input word_t w57, input word_t w58, input word_t w59,
                               input bit zero_want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.word_round57 <= $urandom;
      in_ch.word_round58 <= $urandom;
      in_ch.word_round59 <= $urandom;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word_round57 <= w57;
    in_ch.word_round58 <= w58;
    in_ch.word_round59 <= w59;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (zero_want) round59_pairs.push_back('0);
    else round59_pairs.push_back(cascade_rounds(base_pairs, w57, w58, w59));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (round59_pairs.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_base(input pair_set_t v);
    for (int i = REG_A; i <= REG_H; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= cfg_idx_t'(i);
      cfg_wdata <= v[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    base_pairs = v;
    base_settings++;
    @(negedge clk);
  endtask

  task automatic walk_directed(input bit base_zero);
    for (int r = 0; r < DIRECTED_ROWS; r++)
      offer_request(DIRECTED[r].w57, DIRECTED[r].w58, DIRECTED[r].w59,
                    base_zero && DIRECTED[r].zero_want);
  endtask

  initial begin
    int hold;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.word_round57 = '0;
    in_ch.word_round58 = '0;
    in_ch.word_round59 = '0;
    out_ch.ready = 1'b0;
    base_pairs = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    error_count = 0;
    requests_sent = 0;
    results_seen = 0;
    base_settings = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers never written read as zero
    walk_directed(1'b1);
    wait_for_results();
    load_base(make_base(BASE_ONES));
    walk_directed(1'b0);
    wait_for_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 80;
      end else if (p < 6) begin
        send_idle_pct = 80;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_base(make_base(p < BASE_RANDOM ? base_kind_t'(p) : BASE_RANDOM));
      hold = $urandom_range(PHASE_ITEMS - 1);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (j == hold) wait_for_results();
        offer_request(pick_word(K57), pick_word(K58), pick_word(K59), 1'b0);
      end
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d requests, %0d results checked, %0d base register settings",
             requests_sent, results_seen, base_settings);
    $display("stalls: sender-light, receiver-light and none; %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("[sha256_cascade_three_round_pair] OK");
    end else begin
      $display("[sha256_cascade_three_round_pair] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results pending", round59_pairs.size());
    $display("[sha256_cascade_three_round_pair] ERROR");
    $finish;
  end

endmodule

// ===== sha256_cascade_three_round_pair.f =====
+incdir+rtl/core
rtl/core/s256c_pkg.sv
rtl/core/s256c_in_if.sv
rtl/core/s256c_out_if.sv
rtl/core/s256c_cell.sv
rtl/core/sha256_cascade_three_round_pair.sv
tb/sv/tb_sha256_cascade_three_round_pair.sv
